// ===== src/lmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsf_pkg: shared types and constants for the scrolling LED frame generator
// Item codes, queue entry layout and the driver set-up table.
// ----------------------------------------------------------------------------
`default_nettype none

package lmsf_pkg;

    // input item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_INIT = 2'd2;

    // driver register addresses
    localparam logic [3:0] REG_DECODE    = 4'h9;
    localparam logic [3:0] REG_INTENSITY = 4'hA;
    localparam logic [3:0] REG_SCANLIM   = 4'hB;
    localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
    localparam logic [3:0] REG_TEST      = 4'hF;

    localparam int ROWS        = 8;
    localparam int INIT_FRAMES = 5;
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_TICK,
        CMD_INIT
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] idx;
        logic [7:0] bits;
    } q_entry_t;

    // set-up sequence: shutdown off, test off, no decode, scan limit 7, intensity 0
    function automatic logic [3:0] init_addr(input logic [2:0] step);
        logic [3:0] a;
        case (step)
            3'd0:    a = REG_SHUTDOWN;
            3'd1:    a = REG_TEST;
            3'd2:    a = REG_DECODE;
            3'd3:    a = REG_SCANLIM;
            3'd4:    a = REG_INTENSITY;
            default: a = 4'h0;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] init_data(input logic [2:0] step);
        logic [7:0] d;
        case (step)
            3'd0:    d = 8'h01;
            3'd3:    d = 8'h07;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/lmsf_ram.sv =====
// ----------------------------------------------------------------------------
// lmsf_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== src/lmsf_front.sv =====
// ----------------------------------------------------------------------------
// lmsf_front: command intake
// Classifies input words, drops unused kinds, queues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       kind,
    input  wire logic [3:0]       column_index,
    input  wire logic [7:0]       column_bits,
    output logic                  busy,
    output logic                  head_valid,
    output lmsf_pkg::q_entry_t    head,
    input  wire logic             pop
);

    lmsf_pkg::q_entry_t entry_reg [lmsf_pkg::QDEPTH];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               known;
    logic               push;
    lmsf_pkg::cmd_t     cmd;
    lmsf_pkg::q_entry_t new_entry;

    always_comb
    begin
        known = 1'b1;
        cmd   = lmsf_pkg::CMD_LOAD;
        case (kind)
            lmsf_pkg::KIND_LOAD: cmd = lmsf_pkg::CMD_LOAD;
            lmsf_pkg::KIND_TICK: cmd = lmsf_pkg::CMD_TICK;
            lmsf_pkg::KIND_INIT: cmd = lmsf_pkg::CMD_INIT;
            default:             known = 1'b0;
        endcase
    end

    assign busy       = (count_reg == 2'(lmsf_pkg::QDEPTH));
    assign push       = start && !busy && known;
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    assign new_entry.cmd  = cmd;
    assign new_entry.idx  = column_index;
    assign new_entry.bits = column_bits;

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(lmsf_pkg::QDEPTH))
        else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== src/lmsf_back.sv =====
// ----------------------------------------------------------------------------
// lmsf_back: frame engine
// Executes queued commands: bitmap writes, scroll frames and set-up frames.
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_back #(
    parameter int COLUMNS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire lmsf_pkg::q_entry_t head,
    output logic                    pop,
    output logic                    frame_valid,
    output logic [3:0]              reg_addr,
    output logic [7:0]              near_data,
    output logic [7:0]              far_data,
    output logic                    last_frame
);

    localparam int AW = $clog2(COLUMNS);
    localparam logic [AW:0]  COL_LIM = (AW+1)'(COLUMNS);
    localparam logic [AW-1:0] OFF_MAX = AW'(COLUMNS - 1);
    localparam logic [2:0]   ROW_LAST  = 3'(lmsf_pkg::ROWS - 1);
    localparam logic [2:0]   INIT_LAST = 3'(lmsf_pkg::INIT_FRAMES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_INIT
    } state_t;

    state_t          state_reg;
    logic [2:0]      row_reg;
    logic [AW-1:0]   off_reg;
    logic [COLUMNS-1:0] valid_reg;
    logic            p_valid_reg, p_last_reg, p_mem_reg;
    logic [3:0]      p_addr_reg;
    logic [7:0]      p_const_reg;
    logic            nv_reg, fv_reg;

    logic            issue_tick, issue_init, we;
    logic [2:0]      row;
    logic [AW:0]     near_sum, far_sum;
    logic [AW-1:0]   near_addr, far_addr, waddr;
    logic [7:0]      rd_near, rd_far;

    assign pop        = (state_reg == ST_IDLE) && head_valid;
    assign we         = pop && (head.cmd == lmsf_pkg::CMD_LOAD);
    assign issue_tick = (pop && (head.cmd == lmsf_pkg::CMD_TICK)) || (state_reg == ST_TICK);
    assign issue_init = (pop && (head.cmd == lmsf_pkg::CMD_INIT)) || (state_reg == ST_INIT);
    assign row        = (state_reg == ST_IDLE) ? 3'd0 : row_reg;
    assign waddr      = AW'(head.idx);

    // column pair for this row, wrapped once at the bitmap width
    always_comb
    begin
        near_sum  = {1'b0, off_reg} + (AW+1)'(row);
        far_sum   = {1'b0, off_reg} + (AW+1)'(row) + (AW+1)'(lmsf_pkg::ROWS);
        near_addr = (near_sum >= COL_LIM) ? AW'(near_sum - COL_LIM) : AW'(near_sum);
        far_addr  = (far_sum >= COL_LIM) ? AW'(far_sum - COL_LIM) : AW'(far_sum);
    end

    lmsf_ram #(
        .WIDTH (8),
        .DEPTH (COLUMNS)
    ) u_bitmap (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (head.bits),
        .raddr_a (near_addr),
        .rdata_a (rd_near),
        .raddr_b (far_addr),
        .rdata_b (rd_far)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_reg     <= 3'd0;
            off_reg     <= '0;
            valid_reg   <= '0;
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            p_mem_reg   <= 1'b0;
            p_addr_reg  <= 4'h0;
            p_const_reg <= 8'h00;
            nv_reg      <= 1'b0;
            fv_reg      <= 1'b0;
        end
        else
        begin
            p_valid_reg <= issue_tick || issue_init;
            p_last_reg  <= (issue_tick && (row == ROW_LAST)) ||
                           (issue_init && (row == INIT_LAST));
            p_mem_reg   <= issue_tick;
            p_addr_reg  <= issue_tick ? (4'(row) + 4'd1) : lmsf_pkg::init_addr(row);
            p_const_reg <= lmsf_pkg::init_data(row);
            nv_reg      <= valid_reg[near_addr];
            fv_reg      <= valid_reg[far_addr];
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        case (head.cmd)
                            lmsf_pkg::CMD_TICK:
                            begin
                                state_reg <= ST_TICK;
                                row_reg   <= 3'd1;
                            end
                            lmsf_pkg::CMD_INIT:
                            begin
                                state_reg <= ST_INIT;
                                row_reg   <= 3'd1;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_TICK:
                begin
                    if (row_reg == ROW_LAST)
                    begin
                        state_reg <= ST_IDLE;
                        off_reg   <= (off_reg == OFF_MAX) ? '0 : off_reg + AW'(1);
                    end
                    else
                    begin
                        row_reg <= row_reg + 3'd1;
                    end
                end
                ST_INIT:
                begin
                    if (row_reg == INIT_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        row_reg <= row_reg + 3'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // never-written columns read as zero
    assign frame_valid = p_valid_reg;
    assign reg_addr    = p_addr_reg;
    assign last_frame  = p_last_reg;
    assign near_data   = p_mem_reg ? (nv_reg ? rd_near : 8'h00) : p_const_reg;
    assign far_data    = p_mem_reg ? (fv_reg ? rd_far : 8'h00) : p_const_reg;

`ifndef NO_ASSERTIONS
    a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, off_reg} < COL_LIM)
        else $error("scroll offset out of range");
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_frame |-> frame_valid)
        else $error("last frame without strobe");
`endif

endmodule

`default_nettype wire

// ===== src/led_matrix_scroll_frames.sv =====
// ----------------------------------------------------------------------------
// led_matrix_scroll_frames: scrolling frame generator for two chained
// 8x8 LED matrix drivers
// Holds a column bitmap and emits register-update frames for both devices.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken at a clock edge with start high and busy
//   low. kind 0 writes column_bits into bitmap column column_index, kind 1 is
//   a scroll tick, kind 2 sends the driver set-up sequence, kind 3 is dropped.
//   Commands pass through a two-entry queue, so busy rises only when two
//   commands are waiting behind the one being executed.
//   Frame channel: each frame is valid for exactly one cycle, marked by
//   frame_valid; the receiver must take it then and cannot stall the block.
//   A tick gives 8 frames (reg_addr 1..8, one per cycle), then the scroll
//   offset advances; init gives 5 frames. last_frame marks the final one.
//   When the engine is idle, a taken command passes the queue register, then
//   the frame output registers, before its first frame. The engine takes a
//   new command only once the current one has issued its last frame; it reads
//   one near/far column pair per frame from the bitmap RAM, which sets the one-frame-per-cycle rate.
//   Reset: the bitmap reads as all zeros (per-column valid flags), the
//   scroll offset is zero and the queue is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_scroll_frames #(
    parameter int COLUMNS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] kind,
    input  wire logic [3:0] column_index,
    input  wire logic [7:0] column_bits,
    output logic            busy,
    output logic            frame_valid,
    output logic [3:0]      reg_addr,
    output logic [7:0]      near_data,
    output logic [7:0]      far_data,
    output logic            last_frame
);

    lmsf_pkg::q_entry_t head;
    logic               head_valid;
    logic               pop;

    // intake and queue
    lmsf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .column_index (column_index),
        .column_bits  (column_bits),
        .busy         (busy),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop)
    );

    // bitmap store and frame sequencer
    lmsf_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .frame_valid (frame_valid),
        .reg_addr    (reg_addr),
        .near_data   (near_data),
        .far_data    (far_data),
        .last_frame  (last_frame)
    );

endmodule

`default_nettype wire
